// ----- rtl/psm_pkg.sv -----
// Package for the priority schedule block: field widths, divider selection codes
// and the command and status structs that join controller and datapath.
// Depends on nothing.
package psm_pkg;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 5;
    localparam int TIME_W  = 20;
    localparam int AVG_W   = 28;
    localparam int THR_W   = 21;
    localparam int FRAC_AVG = 8;
    localparam int FRAC_THR = 16;
    localparam logic [THR_W-1:0] THR_SAT = {THR_W{1'b1}};

    typedef enum logic [1:0] {
        DIV_WAIT_AVG = 2'd0,
        DIV_TURN_AVG = 2'd1,
        DIV_THRU     = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     scan_start;
        logic     acc;
        logic     div_start;
        logic     div_store;
        t_div_sel div_sel;
        logic     clear;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic last;
        logic div_done;
    } t_sts;

endpackage

// ----- rtl/psm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by psm_datapath.
module psm_div #(
    parameter int DW = 40,
    parameter int VW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      cand;
    logic             ge;

    assign cand = {r_rem, r_quo[DW-1]};
    assign ge   = cand >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? VW'(cand - {1'b0, r_div}) : cand[VW-1:0];
                r_quo <= {r_quo[DW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- rtl/psm_datapath.sv -----
// Datapath: process memory, selection scan, time accumulators, shared divider
// and the result register. Depends on psm_pkg and psm_div.
module psm_datapath #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [psm_pkg::BURST_W-1:0] i_burst,
    input  logic [psm_pkg::PRIO_W-1:0]  i_prio,
    input  psm_pkg::t_cmd             i_cmd,
    output psm_pkg::t_sts             o_sts,
    output logic [psm_pkg::ID_W-1:0]    o_id,
    output logic [psm_pkg::BURST_W-1:0] o_burst,
    output logic [psm_pkg::TIME_W-1:0]  o_completion,
    output logic [psm_pkg::TIME_W-1:0]  o_waiting,
    output logic [psm_pkg::AVG_W-1:0]   o_avg_wait,
    output logic [psm_pkg::AVG_W-1:0]   o_avg_turn,
    output logic [psm_pkg::THR_W-1:0]   o_thru,
    output logic                      o_last
);
    localparam int CW    = $clog2(MAX_PROCESSES + 1);
    localparam int AW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RT_W  = psm_pkg::BURST_W + CW;
    localparam int SUM_W = RT_W + CW;
    localparam int DVD_W = SUM_W + psm_pkg::FRAC_AVG;
    localparam int MW    = psm_pkg::BURST_W + psm_pkg::PRIO_W;

    logic [MW-1:0]            r_mem [MAX_PROCESSES];
    logic [MW-1:0]            r_rd;
    logic [AW-1:0]            r_rd_idx;
    logic                     r_rd_vld;
    logic                     r_rd_last;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_scan_cnt;
    logic                     r_scanning;
    logic                     r_scan_done;
    logic [MAX_PROCESSES-1:0] r_emitted;
    logic                     r_best_vld;
    logic [AW-1:0]            r_best_idx;
    logic [psm_pkg::PRIO_W-1:0]  r_best_prio;
    logic [psm_pkg::BURST_W-1:0] r_best_burst;
    logic [CW-1:0]            r_rank;
    logic [RT_W-1:0]          r_running;
    logic [SUM_W-1:0]         r_tsum;
    logic [SUM_W-1:0]         r_wsum;
    logic [RT_W-1:0]          n_running;
    logic [psm_pkg::PRIO_W-1:0]  rd_prio;
    logic                     take;
    logic [DVD_W-1:0]         div_dvd;
    logic [RT_W-1:0]          div_dvs;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quo;

    assign rd_prio   = r_rd[MW-1:psm_pkg::BURST_W];
    assign take      = r_rd_vld && !r_emitted[r_rd_idx]
                       && (!r_best_vld || rd_prio < r_best_prio);
    assign n_running = r_running + RT_W'(r_best_burst);

    // Process memory: written while loading, read once a cycle by the scan.
    always_ff @(posedge i_clk) begin
        if (i_load && r_count < CW'(MAX_PROCESSES)) begin
            r_mem[r_count[AW-1:0]] <= {i_prio, i_burst};
        end
        r_rd <= r_mem[r_scan_cnt[AW-1:0]];
    end

    always_comb begin
        div_dvd = '0;
        div_dvs = RT_W'(r_count);
        case (i_cmd.div_sel)
            psm_pkg::DIV_WAIT_AVG: div_dvd = {r_wsum, psm_pkg::FRAC_AVG'(0)};
            psm_pkg::DIV_TURN_AVG: div_dvd = {r_tsum, psm_pkg::FRAC_AVG'(0)};
            psm_pkg::DIV_THRU: begin
                div_dvd = DVD_W'({r_count, psm_pkg::FRAC_THR'(0)});
                div_dvs = r_running;
            end
            default: div_dvd = '0;
        endcase
    end

    psm_div #(.DW(DVD_W), .VW(RT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan_cnt  <= '0;
            r_scanning  <= 1'b0;
            r_scan_done <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_emitted   <= '0;
            r_best_vld  <= 1'b0;
            r_rank      <= '0;
            r_running   <= '0;
            r_tsum      <= '0;
            r_wsum      <= '0;
        end else begin
            if (i_load && r_count < CW'(MAX_PROCESSES)) begin
                r_count <= r_count + 1'b1;
            end
            r_rd_vld  <= r_scanning;
            r_rd_last <= r_scanning && (r_scan_cnt == r_count - 1'b1);
            r_rd_idx  <= r_scan_cnt[AW-1:0];
            if (i_cmd.scan_start) begin
                r_scanning  <= 1'b1;
                r_scan_cnt  <= '0;
                r_scan_done <= 1'b0;
                r_best_vld  <= 1'b0;
            end else if (r_scanning) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
                if (r_scan_cnt == r_count - 1'b1) begin
                    r_scanning <= 1'b0;
                end
            end
            if (take) begin
                r_best_vld   <= 1'b1;
                r_best_idx   <= r_rd_idx;
                r_best_prio  <= rd_prio;
                r_best_burst <= r_rd[psm_pkg::BURST_W-1:0];
            end
            if (r_rd_vld && r_rd_last) begin
                r_scan_done <= 1'b1;
            end
            if (i_cmd.acc) begin
                r_running             <= n_running;
                r_tsum                <= r_tsum + SUM_W'(n_running);
                r_wsum                <= r_wsum + SUM_W'(r_running);
                r_emitted[r_best_idx] <= 1'b1;
                r_rank                <= r_rank + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_emitted <= '0;
                r_rank    <= '0;
                r_running <= '0;
                r_tsum    <= '0;
                r_wsum    <= '0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            o_id         <= psm_pkg::ID_W'(r_best_idx) + 1'b1;
            o_burst      <= r_best_burst;
            o_completion <= n_running[psm_pkg::TIME_W-1:0];
            o_waiting    <= r_running[psm_pkg::TIME_W-1:0];
            o_avg_wait   <= '0;
            o_avg_turn   <= '0;
            o_thru       <= '0;
            o_last       <= (r_rank + 1'b1) == r_count;
        end
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                psm_pkg::DIV_WAIT_AVG: o_avg_wait <= div_quo[psm_pkg::AVG_W-1:0];
                psm_pkg::DIV_TURN_AVG: o_avg_turn <= div_quo[psm_pkg::AVG_W-1:0];
                psm_pkg::DIV_THRU: begin
                    if (r_running == '0 || div_quo > DVD_W'(psm_pkg::THR_SAT)) begin
                        o_thru <= psm_pkg::THR_SAT;
                    end else begin
                        o_thru <= div_quo[psm_pkg::THR_W-1:0];
                    end
                end
                default: o_thru <= o_thru;
            endcase
        end
    end

    assign o_sts.scan_done = r_scan_done;
    assign o_sts.last      = o_last;
    assign o_sts.div_done  = div_done;
endmodule

// ----- rtl/psm_ctrl.sv -----
// Controller state machine that sequences loading, selection, accumulation,
// averaging and throughput divisions and result delivery. Depends on psm_pkg.
module psm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    input  logic          i_m_tready,
    input  psm_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    output psm_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {
        ST_LOAD, ST_START, ST_SCAN, ST_ACC, ST_CHECK, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } t_state;

    t_state            r_state, n_state;
    psm_pkg::t_div_sel r_sel, n_sel;

    always_comb begin
        n_state           = r_state;
        n_sel             = r_sel;
        o_cmd             = '0;
        o_cmd.div_sel     = r_sel;
        case (r_state)
            ST_LOAD: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.scan_start = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_CHECK;
            end
            ST_CHECK: begin
                n_sel   = psm_pkg::DIV_WAIT_AVG;
                n_state = i_sts.last ? ST_DIV_GO : ST_OUT;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    case (r_sel)
                        psm_pkg::DIV_WAIT_AVG: begin
                            n_sel   = psm_pkg::DIV_TURN_AVG;
                            n_state = ST_DIV_GO;
                        end
                        psm_pkg::DIV_TURN_AVG: begin
                            n_sel   = psm_pkg::DIV_THRU;
                            n_state = ST_DIV_GO;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    o_cmd.clear = i_sts.last;
                    n_state     = i_sts.last ? ST_LOAD : ST_START;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_sel   <= psm_pkg::DIV_WAIT_AVG;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_s_tready = r_state == ST_LOAD;
    assign o_m_tvalid = r_state == ST_OUT;
endmodule

// ----- rtl/priority_schedule_metrics.sv -----
// Top level of the non-preemptive priority scheduler with batch metrics.
// Depends on psm_pkg, psm_ctrl and psm_datapath (which holds psm_div).
//
// Each accepted input transaction loads one process (burst time and priority
// number); ids are given from 1 in arrival order and up to MAX_PROCESSES are
// kept, further processes being dropped. Loading accepts transactions
// back to back. The transaction with tlast set closes the set: the block then
// emits one output transaction per process in ascending priority order, equal
// priorities keeping arrival order, with completion time (equal to turnaround
// time, as all processes arrive at zero) and waiting time. The transaction with
// tlast set on the output also carries the mean waiting and turnaround times
// (8 fractional bits, truncated) and the throughput, processes per time unit
// with 16 fractional bits, saturated at all ones when the total time is zero
// or the quotient overflows; these fields are zero on every other result.
// For each result a selection scan reads the process memory one entry a cycle
// to find the next process; the last result adds three divisions on one
// shared restoring divider. No new input is taken until the last result of a
// set has been delivered.
module priority_schedule_metrics #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [23:0]  i_s_tdata,  // burst_time[15:0], priority_level[23:16]
    input  logic         i_s_tlast,  // final_item
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // process_id[4:0], burst_out[20:5], completion_time[40:21],
    // waiting_time[60:41], avg_waiting[88:61], avg_turnaround[116:89],
    // throughput[137:117], zeros above
    output logic [143:0] o_m_tdata,
    output logic         o_m_tlast   // last_result
);
    psm_pkg::t_cmd cmd;
    psm_pkg::t_sts sts;
    logic          load;

    logic [psm_pkg::ID_W-1:0]    id;
    logic [psm_pkg::BURST_W-1:0] burst;
    logic [psm_pkg::TIME_W-1:0]  completion;
    logic [psm_pkg::TIME_W-1:0]  waiting;
    logic [psm_pkg::AVG_W-1:0]   avg_wait;
    logic [psm_pkg::AVG_W-1:0]   avg_turn;
    logic [psm_pkg::THR_W-1:0]   thru;

    // A process is written on every accepted input transaction while fewer than MAX_PROCESSES are held.
    assign load = i_s_tvalid && o_s_tready;

    psm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    psm_datapath #(.MAX_PROCESSES(MAX_PROCESSES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (i_s_tdata[15:0]),
        .i_prio       (i_s_tdata[23:16]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_id         (id),
        .o_burst      (burst),
        .o_completion (completion),
        .o_waiting    (waiting),
        .o_avg_wait   (avg_wait),
        .o_avg_turn   (avg_turn),
        .o_thru       (thru),
        .o_last       (o_m_tlast)
    );

    // Pack the result fields from the lowest bit up, padded to whole bytes.
    assign o_m_tdata = {6'd0, thru, avg_turn, avg_wait, waiting, completion, burst, id};
endmodule
